### rtl/rvig_pkg.sv
// ============================================================================
// rvig_pkg - shared constants and types for the radial vignette pixel block
// Fixed-point widths of the distance, scale and channel datapath, and the
// configuration register indexes.
// ============================================================================
package rvig_pkg;

    // Frame dimension limits and distance format
    localparam int MAX_DIM        = 4096;
    localparam int DIST_FRAC_BITS = 8;

    // Field widths
    localparam int DIM_W   = 13;   // image_width / image_height registers
    localparam int COORD_W = 12;   // pixel_row / pixel_col
    localparam int CHAN_W  = 8;    // one color channel
    localparam int NUM_CH  = 3;

    // Offset from center, doubled: |2*coord - dim| stays below 2^DIM_W
    localparam int OFS_W = DIM_W;
    localparam int SQR_W = 2 * OFS_W;
    localparam int SUM_W = SQR_W + 1;

    // Square root operand: sum scaled to carry DIST_FRAC_BITS fraction bits
    localparam int SQ_SHIFT   = 2 * DIST_FRAC_BITS - 2;
    localparam int SQ_IN_W    = SUM_W + SQ_SHIFT;
    localparam int SQ_W       = SQ_IN_W + 1;
    localparam int ROOT_W     = (SQ_IN_W + 1) / 2;
    localparam int SQRT_STEPS = ROOT_W;

    // Radius (height) in distance format, and the channel products
    localparam int RAD_W  = DIM_W + DIST_FRAC_BITS;
    localparam int PROD_W = CHAN_W + RAD_W;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    // Three channels, red in the lowest byte
    typedef logic [NUM_CH-1:0][CHAN_W-1:0] t_rgb;

endpackage

### rtl/radial_vignette_pixel_top.sv
// An input beat passes the offset, square, sum, root, keep, product, divide
// and output registers on its way to m_axis. Throughput: one pixel per clock;
// the pipeline advances whenever the output skid register is empty, so
// m_axis_tready has no combinational path to s_axis_tready. Depth is set by
// the 21-stage square root and 8-stage divide. Reset (synchronous, active low)
// empties the pipeline and sets both frame dimensions to 1.
// ============================================================================
// radial_vignette_pixel_top - linear radial vignette, one RGB pixel per beat
// Distance to frame center by a pipelined bit-per-stage square root, then
// each channel scaled by (H - dist) / H through a pipelined restoring divide.
// ============================================================================
module radial_vignette_pixel_top
    import rvig_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [DIM_W-1:0]     i_cfg_data,
    // pixel input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [47:0]          s_axis_tdata,   // pixel_row, pixel_col, in_red, in_green, in_blue
    // pixel output stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [23:0]          m_axis_tdata    // out_red, out_green, out_blue
);

    // ------------------------------------------------------------------------
    // Configuration registers, stored already clamped to 1..MAX_DIM
    // ------------------------------------------------------------------------
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic [DIM_W-1:0] n_dim;

    always_comb begin
        if (i_cfg_data == '0) begin
            n_dim = DIM_W'(1);
        end else if (i_cfg_data > DIM_W'(MAX_DIM)) begin
            n_dim = DIM_W'(MAX_DIM);
        end else begin
            n_dim = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(1);
            r_height <= DIM_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_IMAGE_WIDTH:  r_width  <= n_dim;
                CFG_IMAGE_HEIGHT: r_height <= n_dim;
                default: ;
            endcase
        end
    end

    logic [RAD_W-1:0] w_radius;
    assign w_radius = {r_height, DIST_FRAC_BITS'(0)};

    // ------------------------------------------------------------------------
    // Pipeline advance: every stage moves while the skid register is empty
    // ------------------------------------------------------------------------
    logic r_skid_valid;
    logic w_en;
    assign w_en          = !r_skid_valid;
    assign s_axis_tready = w_en;

    // input field unpacking
    logic [COORD_W-1:0] w_row;
    logic [COORD_W-1:0] w_col;
    t_rgb               w_rgb_in;
    assign w_row    = s_axis_tdata[11:0];
    assign w_col    = s_axis_tdata[23:12];
    assign w_rgb_in = s_axis_tdata[47:24];

    // ------------------------------------------------------------------------
    // Stage 1: doubled offsets from center
    // ------------------------------------------------------------------------
    logic [OFS_W-1:0] n_dx, n_dy;
    logic [OFS_W-1:0] w_col2, w_row2;
    assign w_col2 = {w_col, 1'b0};
    assign w_row2 = {w_row, 1'b0};
    assign n_dx   = (w_col2 >= r_width)  ? (w_col2 - r_width)  : (r_width  - w_col2);
    assign n_dy   = (w_row2 >= r_height) ? (w_row2 - r_height) : (r_height - w_row2);

    logic             r_s1_valid;
    logic [OFS_W-1:0] r_s1_dx, r_s1_dy;
    t_rgb             r_s1_rgb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_dx  <= n_dx;
            r_s1_dy  <= n_dy;
            r_s1_rgb <= w_rgb_in;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: squares
    // ------------------------------------------------------------------------
    logic             r_s2_valid;
    logic [SQR_W-1:0] r_s2_sqx, r_s2_sqy;
    t_rgb             r_s2_rgb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_sqx <= SQR_W'(r_s1_dx) * SQR_W'(r_s1_dx);
            r_s2_sqy <= SQR_W'(r_s1_dy) * SQR_W'(r_s1_dy);
            r_s2_rgb <= r_s1_rgb;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 3: sum of squares, scaled into the square root operand
    // ------------------------------------------------------------------------
    logic             r_sq_valid [0:SQRT_STEPS];
    logic [SQ_W-1:0]  r_sq_x     [0:SQRT_STEPS];
    logic [SQ_W-1:0]  r_sq_root  [0:SQRT_STEPS];
    t_rgb             r_sq_rgb   [0:SQRT_STEPS];
    logic [SUM_W-1:0] n_sum;

    assign n_sum = SUM_W'(r_s2_sqx) + SUM_W'(r_s2_sqy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_valid[0] <= 1'b0;
        end else if (w_en) begin
            r_sq_valid[0] <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_x[0]    <= SQ_W'(n_sum) << SQ_SHIFT;
            r_sq_root[0] <= '0;
            r_sq_rgb[0]  <= r_s2_rgb;
        end
    end

    // ------------------------------------------------------------------------
    // Square root: one result bit per stage, highest bit first
    // ------------------------------------------------------------------------
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        localparam logic [SQ_W-1:0] STEP_BIT = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - k));
        logic [SQ_W-1:0] w_trial;
        logic            w_take;

        assign w_trial = r_sq_root[k] + STEP_BIT;
        assign w_take  = (r_sq_x[k] >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_valid[k+1] <= 1'b0;
            end else if (w_en) begin
                r_sq_valid[k+1] <= r_sq_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                if (w_take) begin
                    r_sq_x[k+1]    <= r_sq_x[k] - w_trial;
                    r_sq_root[k+1] <= (r_sq_root[k] >> 1) + STEP_BIT;
                end else begin
                    r_sq_x[k+1]    <= r_sq_x[k];
                    r_sq_root[k+1] <= r_sq_root[k] >> 1;
                end
                r_sq_rgb[k+1] <= r_sq_rgb[k];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Keep factor: radius minus distance, zero beyond the radius
    // ------------------------------------------------------------------------
    logic [SQ_W-1:0]  w_dist;
    logic [SQ_W-1:0]  w_rad_ext;
    logic [RAD_W-1:0] n_keep;
    logic             r_kp_valid;
    logic [RAD_W-1:0] r_kp_keep;
    t_rgb             r_kp_rgb;

    assign w_dist    = r_sq_root[SQRT_STEPS];
    assign w_rad_ext = SQ_W'(w_radius);
    assign n_keep    = (w_dist < w_rad_ext) ? RAD_W'(w_rad_ext - w_dist) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp_valid <= 1'b0;
        end else if (w_en) begin
            r_kp_valid <= r_sq_valid[SQRT_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_kp_keep <= n_keep;
            r_kp_rgb  <= r_sq_rgb[SQRT_STEPS];
        end
    end

    // ------------------------------------------------------------------------
    // Channel products, which seed the divide pipeline
    // ------------------------------------------------------------------------
    logic                                r_dv_valid [0:CHAN_W];
    logic [NUM_CH-1:0][PROD_W-1:0]       r_dv_rem   [0:CHAN_W];
    t_rgb                                r_dv_q     [0:CHAN_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_valid[0] <= 1'b0;
        end else if (w_en) begin
            r_dv_valid[0] <= r_kp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_dv_rem[0][c] <= PROD_W'(r_kp_rgb[c]) * PROD_W'(r_kp_keep);
            end
            r_dv_q[0] <= '0;
        end
    end

    // ------------------------------------------------------------------------
    // Restoring divide by the radius: one quotient bit per stage
    // ------------------------------------------------------------------------
    for (genvar i = 0; i < CHAN_W; i++) begin : g_div
        localparam int SHIFT = CHAN_W - 1 - i;
        logic [PROD_W-1:0] w_divisor;
        logic [NUM_CH-1:0] w_take;

        assign w_divisor = PROD_W'(w_radius) << SHIFT;

        always_comb begin
            for (int c = 0; c < NUM_CH; c++) begin
                w_take[c] = (r_dv_rem[i][c] >= w_divisor);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_valid[i+1] <= 1'b0;
            end else if (w_en) begin
                r_dv_valid[i+1] <= r_dv_valid[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                for (int c = 0; c < NUM_CH; c++) begin
                    r_dv_rem[i+1][c] <= w_take[c] ? (r_dv_rem[i][c] - w_divisor)
                                                  : r_dv_rem[i][c];
                    r_dv_q[i+1][c]   <= r_dv_q[i][c] | (CHAN_W'(w_take[c]) << SHIFT);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output register with skid stage
    // ------------------------------------------------------------------------
    logic  w_arrive;
    logic  w_out_free;
    logic  r_out_valid;
    t_rgb  r_out_data;
    t_rgb  r_skid_data;

    assign w_arrive   = w_en && r_dv_valid[CHAN_W];
    assign w_out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid  <= r_skid_valid || w_arrive;
            r_skid_valid <= 1'b0;
        end else if (w_arrive) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out_data <= r_skid_valid ? r_skid_data : r_dv_q[CHAN_W];
        end else if (w_arrive) begin
            r_skid_data <= r_dv_q[CHAN_W];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef NO_ASSERTIONS
    // skid holds a beat only behind a stalled output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while output register empty");

    // skid fills only when the previous output beat was not taken
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !m_axis_tready))
        else $error("skid register filled without an output stall");

    // square root result fits its width
    a_root_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sq_valid[SQRT_STEPS] |-> (r_sq_root[SQRT_STEPS] >> ROOT_W) == '0)
        else $error("square root result overflow");

    // keep factor never exceeds the radius
    a_keep_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kp_valid |-> (r_kp_keep <= w_radius))
        else $error("keep factor above radius");

    // every divide leaves a remainder below the radius
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_valid[CHAN_W] |-> (r_dv_rem[CHAN_W][0] < PROD_W'(w_radius))
                            && (r_dv_rem[CHAN_W][1] < PROD_W'(w_radius))
                            && (r_dv_rem[CHAN_W][2] < PROD_W'(w_radius)))
        else $error("divide remainder not reduced");
`endif

endmodule

### verif/tb_radial_vignette_pixel_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radial_vignette_pixel_top - self-checking bench for the radial vignette
// A directed list of pixels walks the frame-size corners: reset size, zero and
// oversized dimensions, odd sizes with half-pixel centers, the exact-radius
// boundary and far-outside pixels. It then sends random pixels over several
// frame settings with random source gaps and sink stalls. Every output beat is
// compared per channel against a local fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_radial_vignette_pixel_top;
    import rvig_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_BEATS = 100;
    localparam int NUM_DIR     = 23;
    localparam int FLUSH_WAIT  = 60;    // pipeline is 35 deep

    // One input pixel; channels red in the lowest byte
    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        t_rgb               rgb;
    } t_pixel;

    // Directed step: frame size, pixel, and an optional typed-in answer
    typedef struct packed {
        logic [DIM_W-1:0]   w;
        logic [DIM_W-1:0]   h;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        t_rgb               rgb;
        bit                 typed;
        t_rgb               want;
    } t_dir_step;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic               i_cfg_idx;
    logic [DIM_W-1:0]   i_cfg_data;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [47:0]        s_axis_tdata;   // pixel_row, pixel_col, in_red, in_green, in_blue
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [23:0]        m_axis_tdata;   // out_red, out_green, out_blue

    radial_vignette_pixel_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Bench copy of the frame registers and the pending output pixels
    logic [DIM_W-1:0] frame_w_reg = DIM_W'(1);
    logic [DIM_W-1:0] frame_h_reg = DIM_W'(1);
    t_rgb             pending_rgb [$];

    int  err_count     = 0;
    int  beats_in      = 0;
    int  beats_checked = 0;
    int  settings_used = 0;
    int  hold_count    = 0;
    int  pause_count   = 0;
    int  cycle_count   = 0;
    int  hold_cycles   = 0;
    bit  gaps_on       = 1'b0;
    bit  stalls_on     = 1'b0;

    t_dir_step dir_steps [0:NUM_DIR-1];

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TIMEOUT after %0d cycles, %0d pixels still pending",
                     cycle_count, pending_rgb.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (err_count < 40)
            $display("MISMATCH @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // A register value of 0 acts as 1; anything above the max acts as the max
    function automatic longint unsigned dim_used(input logic [DIM_W-1:0] v);
        if (v == 0)
            return 64'd1;
        if (v > MAX_DIM)
            return 64'(MAX_DIM);
        return 64'(v);
    endfunction

    // Fixed-point vignette: distance with DIST_FRAC_BITS fraction bits,
    // scale (R - D) / R, floored product, zero beyond the radius
    function automatic t_rgb vignette_rgb(input t_pixel p);
        longint unsigned w_eff, h_eff, dx, dy, dsq, root_fx, trial, radius, keep;
        t_rgb res;
        w_eff = dim_used(frame_w_reg);
        h_eff = dim_used(frame_h_reg);
        dx = (2 * p.col >= w_eff) ? (2 * p.col - w_eff) : (w_eff - 2 * p.col);
        dy = (2 * p.row >= h_eff) ? (2 * p.row - h_eff) : (h_eff - 2 * p.row);
        dsq = (dx * dx + dy * dy) << (2 * DIST_FRAC_BITS - 2);
        // root bit by bit, largest first
        root_fx = 0;
        for (int b = 23; b >= 0; b--) begin
            trial = root_fx | (64'd1 << b);
            if (trial * trial <= dsq)
                root_fx = trial;
        end
        radius = h_eff << DIST_FRAC_BITS;
        keep = (root_fx < radius) ? (radius - root_fx) : 0;
        for (int k = 0; k < NUM_CH; k++)
            res[k] = CHAN_W'((longint'(p.rgb[k]) * keep) / radius);
        return res;
    endfunction

    // Offer one pixel, hold it until accepted, queue its expected output
    task automatic send_pixel(input t_pixel p, input bit typed, input t_rgb typed_rgb);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {p.rgb, p.col, p.row};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_rgb.push_back(typed ? typed_rgb : vignette_rgb(p));
        beats_in++;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every pending pixel has come out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_rgb.size() != 0);
    endtask

    task automatic write_dims(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_IMAGE_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_IMAGE_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        frame_w_reg = w;
        frame_h_reg = h;
        settings_used++;
    endtask

    // Sink side: ready stretches, random stall bursts, and requested hold-offs
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            if (hold_cycles != 0) begin
                m_axis_tready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
                hold_count++;
            end else if (stalls_on && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    // Output check, channel by channel against the oldest pending pixel
    always @(posedge i_clk) begin : out_check
        t_rgb want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_rgb.size() == 0) begin
                report_mismatch($sformatf("output beat %06h with no pixel pending",
                                          m_axis_tdata));
            end else begin
                want = pending_rgb.pop_front();
                if (m_axis_tdata[7:0] !== want[0])
                    report_mismatch($sformatf("beat %0d red: got %0d want %0d",
                                    beats_checked, m_axis_tdata[7:0], want[0]));
                if (m_axis_tdata[15:8] !== want[1])
                    report_mismatch($sformatf("beat %0d green: got %0d want %0d",
                                    beats_checked, m_axis_tdata[15:8], want[1]));
                if (m_axis_tdata[23:16] !== want[2])
                    report_mismatch($sformatf("beat %0d blue: got %0d want %0d",
                                    beats_checked, m_axis_tdata[23:16], want[2]));
                beats_checked++;
            end
        end
    end

    // Stimulus
    initial begin : stim
        t_pixel           pix;
        logic [DIM_W-1:0] w, h;
        longint unsigned  w_eff, h_eff;

        // rgb written as {blue, green, red}
        dir_steps = '{
            // reset size 1x1
            '{13'd1, 13'd1, 12'd0, 12'd0, 24'h0180ff, 1'b0, 24'h0},
            '{13'd1, 13'd1, 12'd4095, 12'd4095, 24'hffffff, 1'b1, 24'h0},
            '{13'd1, 13'd1, 12'd1, 12'd0, 24'hffffff, 1'b0, 24'h0},
            // even frame: exact center keeps the pixel
            '{13'd8, 13'd8, 12'd4, 12'd4, 24'h5a00ff, 1'b1, 24'h5a00ff},
            '{13'd8, 13'd8, 12'd0, 12'd0, 24'hffffff, 1'b0, 24'h0},
            '{13'd8, 13'd8, 12'd0, 12'd4, 24'h804020, 1'b0, 24'h0},
            '{13'd8, 13'd8, 12'd7, 12'd7, 24'hffffff, 1'b0, 24'h0},
            // zero dimensions act as 1
            '{13'd0, 13'd0, 12'd0, 12'd0, 24'hffffff, 1'b0, 24'h0},
            '{13'd0, 13'd0, 12'd4095, 12'd0, 24'hffffff, 1'b1, 24'h0},
            // oversized dimensions act as the max
            '{13'd8191, 13'd8191, 12'd2048, 12'd2048, 24'hc3a5ff, 1'b1, 24'hc3a5ff},
            '{13'd8191, 13'd8191, 12'd0, 12'd0, 24'hffffff, 1'b0, 24'h0},
            '{13'd8191, 13'd8191, 12'd4095, 12'd4095, 24'hffffff, 1'b0, 24'h0},
            // wide and flat, tall and narrow
            '{13'd4096, 13'd1, 12'd0, 12'd2048, 24'hffffff, 1'b0, 24'h0},
            '{13'd4096, 13'd1, 12'd1, 12'd4095, 24'h000000, 1'b1, 24'h0},
            '{13'd1, 13'd4096, 12'd2048, 12'd0, 24'hffffff, 1'b0, 24'h0},
            '{13'd1, 13'd4096, 12'd0, 12'd4095, 24'haa55aa, 1'b0, 24'h0},
            // odd frame, center on a half pixel; far outside the frame
            '{13'd5, 13'd7, 12'd3, 12'd2, 24'h7f7f7f, 1'b0, 24'h0},
            '{13'd5, 13'd7, 12'd0, 12'd4095, 24'hffffff, 1'b1, 24'h0},
            // distance exactly at the radius, one pixel inside, center
            '{13'd100, 13'd100, 12'd50, 12'd150, 24'hffffff, 1'b1, 24'h0},
            '{13'd100, 13'd100, 12'd50, 12'd149, 24'hffffff, 1'b0, 24'h0},
            '{13'd100, 13'd100, 12'd50, 12'd50, 24'h123456, 1'b1, 24'h123456},
            // largest legal frame
            '{13'd4096, 13'd4096, 12'd0, 12'd0, 24'hffffff, 1'b0, 24'h0},
            '{13'd4096, 13'd4096, 12'd4095, 12'd4095, 24'h010101, 1'b0, 24'h0}
        };

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_IMAGE_WIDTH;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed steps, frame size rewritten between groups
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        for (int i = 0; i < NUM_DIR; i++) begin
            if (dir_steps[i].w != frame_w_reg || dir_steps[i].h != frame_h_reg) begin
                drain();
                write_dims(dir_steps[i].w, dir_steps[i].h);
            end
            pix.row = dir_steps[i].row;
            pix.col = dir_steps[i].col;
            pix.rgb = dir_steps[i].rgb;
            send_pixel(pix, dir_steps[i].typed, dir_steps[i].want);
        end

        // random phases, one frame setting each; the last one runs flat out
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case ($urandom_range(0, 5))
                0: begin
                    w = (ph % 2) ? 13'd8191 : 13'd0;
                    h = $urandom_range(0, 1) ? 13'd4096 : 13'd1;
                end
                1, 2: begin
                    w = DIM_W'($urandom_range(1, 64));
                    h = DIM_W'($urandom_range(1, 64));
                end
                3, 4: begin
                    w = DIM_W'($urandom_range(1, MAX_DIM));
                    h = DIM_W'($urandom_range(1, MAX_DIM));
                end
                default: begin
                    w = DIM_W'($urandom_range(0, 8191));
                    h = DIM_W'($urandom_range(0, 8191));
                end
            endcase
            drain();
            write_dims(w, h);
            w_eff     = dim_used(w);
            h_eff     = dim_used(h);
            gaps_on   = (ph != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            stalls_on = (ph != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);

            for (int n = 0; n < PHASE_BEATS; n++) begin
                // long sink hold-off while pixels keep coming
                if (ph == 1 && n == 20)
                    hold_cycles = 300;
                // source pause until the pipeline is empty
                if (ph == 2 && n == 50) begin
                    drain();
                    pause_count++;
                end
                if ($urandom_range(0, 9) < 7) begin
                    pix.row = COORD_W'($urandom_range(0, 32'(h_eff - 1)));
                    pix.col = COORD_W'($urandom_range(0, 32'(w_eff - 1)));
                end else begin
                    pix.row = COORD_W'($urandom_range(0, 4095));
                    pix.col = COORD_W'($urandom_range(0, 4095));
                end
                for (int k = 0; k < NUM_CH; k++) begin
                    if ($urandom_range(0, 15) == 0)
                        pix.rgb[k] = $urandom_range(0, 1) ? 8'hff : 8'h00;
                    else
                        pix.rgb[k] = CHAN_W'($urandom_range(0, 255));
                end
                send_pixel(pix, 1'b0, '0);
            end
        end

        drain();
        repeat (FLUSH_WAIT) @(posedge i_clk);
        if (pending_rgb.size() != 0)
            report_mismatch($sformatf("%0d pixels never came out", pending_rgb.size()));

        $display("Sent %0d pixels over %0d frame settings, checked %0d output beats",
                 beats_in, settings_used, beats_checked);
        $display("Sink hold-offs: %0d, source pauses to empty: %0d, mismatches: %0d",
                 hold_count, pause_count, err_count);
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### filelist.f
rtl/rvig_pkg.sv
rtl/radial_vignette_pixel_top.sv
verif/tb_radial_vignette_pixel_top.sv
